// ===== hdl/deq_pkg.sv =====
package deq_pkg;

	localparam int DEQ_DEPTH      = 16;
	localparam int DEQ_DATA_WIDTH = 8;
	localparam int OP_W           = 3;
	localparam int STATUS_W       = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_REAR  = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_RESP
	} ctrl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;    // request transfer this cycle: execute it
		logic load_out;  // move pending result into the output register
	} deq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;  // output register empty or being drained
	} deq_sts_t;

endpackage

// ===== hdl/deq_req_if.sv =====
interface deq_req_if #(
	parameter int DATA_WIDTH = 8
);
	logic                  valid;
	logic                  ready;
	logic [2:0]            operation;
	logic [DATA_WIDTH-1:0] push_value;

	modport source (output valid, output operation, output push_value, input ready);
	modport sink   (input valid, input operation, input push_value, output ready);
endinterface

// ===== hdl/deq_rsp_if.sv =====
interface deq_rsp_if #(
	parameter int DATA_WIDTH = 8,
	parameter int CNT_W      = 5
);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] read_value;
	logic [1:0]            status;
	logic [CNT_W-1:0]      occupancy;

	modport source (output valid, output read_value, output status, output occupancy,
		input ready);
	modport sink   (input valid, input read_value, input status, input occupancy,
		output ready);
endinterface

// ===== hdl/deq_ctrl.sv =====
module deq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  deq_pkg::deq_sts_t sts,
	output deq_pkg::deq_cmd_t cmd
);
	import deq_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		cmd.accept   = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				// memory read data is ready now; wait for a free output slot
				cmd.load_out = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !cmd.accept)
		else $error("deq_ctrl: accepted two requests in consecutive cycles");

	a_resp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) && !sts.out_free |=> (state_q == ST_RESP))
		else $error("deq_ctrl: result left pending state without being loaded");

	a_load_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (state_q == ST_RESP))
		else $error("deq_ctrl: output loaded with no result pending");

endmodule

// ===== hdl/deq_dpath.sv =====
module deq_dpath #(
	parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
	parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH,
	parameter int CNT_W      = $clog2(DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  deq_pkg::deq_cmd_t       cmd,
	output deq_pkg::deq_sts_t       sts,
	input  logic [deq_pkg::OP_W-1:0] req_operation,
	input  logic [DATA_WIDTH-1:0]   req_push_value,
	output logic                    rsp_valid,
	input  logic                    rsp_ready,
	output logic [DATA_WIDTH-1:0]   rsp_read_value,
	output logic [deq_pkg::STATUS_W-1:0] rsp_status,
	output logic [CNT_W-1:0]        rsp_occupancy
);
	import deq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = $clog2(2 * DEPTH);

	// circular store
	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic [AW-1:0]    front_q;
	logic [CNT_W-1:0] count_q;

	// pending result of the executed request
	logic [STATUS_W-1:0] pend_status_q;
	logic                pend_rd_q;

	// output register
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_value_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [CNT_W-1:0]      out_occ_q;

	// next-state and memory control
	logic [AW-1:0]         front_d;
	logic [CNT_W-1:0]      count_d;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic                  re;
	logic [AW-1:0]         raddr;
	logic [STATUS_W-1:0]   status_d;

	logic          full;
	logic          empty;
	logic [AW-1:0] front_dec;
	logic [AW-1:0] front_inc;
	logic [SW-1:0] tail_sum;
	logic [SW-1:0] rear_sum;
	logic [AW-1:0] tail_pos;
	logic [AW-1:0] rear_pos;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);

	// tail = first free slot after the rear; rear = last element
	assign tail_sum = SW'(front_q) + SW'(count_q);
	assign rear_sum = tail_sum - SW'(1);
	assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
	assign rear_pos = (rear_sum >= SW'(DEPTH)) ? AW'(rear_sum - SW'(DEPTH)) : AW'(rear_sum);

	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		we       = 1'b0;
		waddr    = front_dec;
		re       = 1'b0;
		raddr    = front_q;
		status_d = STATUS_OK;
		case (req_operation)
			OP_PUSH_FRONT: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					front_d = front_dec;
					we      = 1'b1;
					waddr   = front_dec;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_PUSH_REAR: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					we      = 1'b1;
					waddr   = tail_pos;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					re      = 1'b1;
					raddr   = front_q;
					front_d = front_inc;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_POP_REAR: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					re      = 1'b1;
					raddr   = rear_pos;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_PEEK_FRONT: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					re    = 1'b1;
					raddr = front_q;
				end
			end
			OP_PEEK_REAR: begin
				if (empty) begin
					status_d = STATUS_EMPTY;
				end else begin
					re    = 1'b1;
					raddr = rear_pos;
				end
			end
			default: begin
				// unused codes: no operation
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && we) begin
			mem[waddr] <= req_push_value;
		end
		if (cmd.accept && re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pend_status_q <= status_d;
			pend_rd_q     <= re;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_value_q  <= pend_rd_q ? rdata_q : '0;
			out_status_q <= pend_status_q;
			out_occ_q    <= count_q;
		end
	end

	assign sts.out_free   = !out_valid_q || rsp_ready;
	assign rsp_valid      = out_valid_q;
	assign rsp_read_value = out_value_q;
	assign rsp_status     = out_status_q;
	assign rsp_occupancy  = out_occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("deq_dpath: element count above depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= AW'(DEPTH - 1))
		else $error("deq_dpath: front index outside store");

	a_full_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && full
			&& (req_operation == OP_PUSH_FRONT || req_operation == OP_PUSH_REAR)
		|=> $stable(count_q) && $stable(front_q))
		else $error("deq_dpath: push into a full deque changed state");

	a_error_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q != STATUS_OK) |-> (out_value_q == '0))
		else $error("deq_dpath: error result carries a non-zero element");

endmodule

// ===== hdl/double_ended_queue_top.sv =====
// Channel  Dir  Payload                                   Transfer when
// req      in   operation[2:0], push_value[DATA_WIDTH-1:0]  req.valid && req.ready
// rsp      out  read_value, status[1:0], occupancy       rsp.valid && rsp.ready
//
// Each request is executed in its transfer cycle against the front index and
// count, which also issues the store access; the ST_RESP state that follows
// picks up the registered read data. The registered store read sets this.
// Reset clears front index, count and the output register; the store is not
// cleared and needs no sweep.
// A stalled rsp holds its result; the next request is taken meanwhile and
// waits in the pending stage until the output register frees.
module double_ended_queue_top #(
	parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
	parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);
	import deq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	deq_cmd_t cmd;
	deq_sts_t sts;

	// sequencer: accepts a request, then hands its result on
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// store, pointers and output register
	deq_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.CNT_W      (CNT_W)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_operation  (req.operation),
		.req_push_value (req.push_value),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_read_value (rsp.read_value),
		.rsp_status     (rsp.status),
		.rsp_occupancy  (rsp.occupancy)
	);

endmodule

// ===== verif/deq_checker.sv =====
module deq_checker #(
	parameter int DEPTH      = deq_pkg::DEQ_DEPTH,
	parameter int DATA_WIDTH = deq_pkg::DEQ_DATA_WIDTH,
	parameter int CNT_W      = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_ready,
	input  logic [deq_pkg::OP_W-1:0]       operation,
	input  logic [DATA_WIDTH-1:0]          push_value,
	input  logic                           rsp_valid,
	input  logic                           rsp_ready,
	input  logic [DATA_WIDTH-1:0]          read_value,
	input  logic [deq_pkg::STATUS_W-1:0]   status,
	input  logic [CNT_W-1:0]               occupancy,
	output int                             fail_count,
	output int                             outstanding
);
	import deq_pkg::*;

	typedef struct {
		logic [DATA_WIDTH-1:0] value;
		status_t               st;
		logic [CNT_W-1:0]      occ;
	} deq_result_t;

	// shadow deque
	logic [DATA_WIDTH-1:0] shadow_store [DEPTH];
	int unsigned           head_idx;
	int unsigned           held;

	deq_result_t due_results [$];
	deq_result_t oldest;

	task automatic note_mismatch(input string what, input longint got, input longint want);
		$display("%0t deq_checker: %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	// apply one operation to the shadow deque, return the result it should give
	function automatic deq_result_t apply_op(input logic [OP_W-1:0] op,
		input logic [DATA_WIDTH-1:0] value);
		deq_result_t r;
		int unsigned tail;
		r.value = '0;
		r.st    = STATUS_OK;
		tail    = (head_idx + held + DEPTH - 1) % DEPTH;
		case (op)
			OP_PUSH_FRONT: begin
				if (held == DEPTH) begin
					r.st = STATUS_FULL;
				end else begin
					head_idx = (head_idx + DEPTH - 1) % DEPTH;
					shadow_store[head_idx] = value;
					held++;
				end
			end
			OP_PUSH_REAR: begin
				if (held == DEPTH) begin
					r.st = STATUS_FULL;
				end else begin
					shadow_store[(head_idx + held) % DEPTH] = value;
					held++;
				end
			end
			OP_POP_FRONT: begin
				if (held == 0) begin
					r.st = STATUS_EMPTY;
				end else begin
					r.value  = shadow_store[head_idx];
					head_idx = (head_idx + 1) % DEPTH;
					held--;
				end
			end
			OP_POP_REAR: begin
				if (held == 0) begin
					r.st = STATUS_EMPTY;
				end else begin
					r.value = shadow_store[tail];
					held--;
				end
			end
			OP_PEEK_FRONT: begin
				if (held == 0) r.st = STATUS_EMPTY;
				else r.value = shadow_store[head_idx];
			end
			OP_PEEK_REAR: begin
				if (held == 0) r.st = STATUS_EMPTY;
				else r.value = shadow_store[tail];
			end
			default: ;
		endcase
		r.occ = CNT_W'(held);
		return r;
	endfunction

	// response side first: a result always belongs to an earlier request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_idx = 0;
			held = 0;
			due_results.delete();
			outstanding = 0;
			fail_count = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (due_results.size() == 0) begin
					note_mismatch("result with none pending, read_value", read_value, 0);
				end else begin
					oldest = due_results.pop_front();
					if (read_value !== oldest.value)
						note_mismatch("read_value", read_value, oldest.value);
					if (status !== oldest.st)
						note_mismatch("status", status, oldest.st);
					if (occupancy !== oldest.occ)
						note_mismatch("occupancy", occupancy, oldest.occ);
				end
			end
			if (req_valid && req_ready)
				due_results.push_back(apply_op(operation, push_value));
			outstanding = due_results.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
// Testbench for the double-ended queue.
// Stimulus lives here; deq_checker watches both channels, keeps a shadow
// deque and compares every response transfer against it.
module tb;
	import deq_pkg::*;

	localparam int CNT_W            = $clog2(DEQ_DEPTH + 1);
	localparam int RANDOM_PER_PHASE = 175;
	// pending stage and output register: extra idle time once the checker has drained
	localparam int SETTLE_CYCLES    = 10;

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   snk_stall_pct;
	int   fail_count;
	int   pending;

	deq_req_if #(.DATA_WIDTH(DEQ_DATA_WIDTH)) req_ch ();
	deq_rsp_if #(.DATA_WIDTH(DEQ_DATA_WIDTH), .CNT_W(CNT_W)) rsp_ch ();

	double_ended_queue_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deq_checker #(
		.DEPTH      (DEQ_DEPTH),
		.DATA_WIDTH (DEQ_DATA_WIDTH),
		.CNT_W      (CNT_W)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_ch.valid),
		.req_ready   (req_ch.ready),
		.operation   (req_ch.operation),
		.push_value  (req_ch.push_value),
		.rsp_valid   (rsp_ch.valid),
		.rsp_ready   (rsp_ch.ready),
		.read_value  (rsp_ch.read_value),
		.status      (rsp_ch.status),
		.occupancy   (rsp_ch.occupancy),
		.fail_count  (fail_count),
		.outstanding (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Backstop: far beyond the slowest legal run (728 transfers, each with
	// sender gaps and receiver stalls).
	initial begin
		#2_000_000;
		$display("double_ended_queue_top: mismatch");
		$finish;
	end

	// Receiver: ready redrawn each falling edge, so stalls land on any
	// phase of the request pipe, including the pending slot.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// One request transfer. Valid is only ever set once per falling edge:
	// either lowered for an idle gap or raised with the next item, never both.
	task automatic send_op(input op_t op, input logic [DEQ_DATA_WIDTH-1:0] value);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= op;
		req_ch.push_value <= value;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Operation mix per burst: filling bursts drive the deque up against
	// full, draining bursts pull it down to empty, mixed bursts wander.
	function automatic op_t pick_op(input int mode);
		int r;
		r = $urandom_range(99);
		if (mode == 0 && r < 70)
			return r[0] ? OP_PUSH_REAR : OP_PUSH_FRONT;
		if (mode == 1 && r < 50)
			return r[0] ? OP_POP_REAR : OP_POP_FRONT;
		if (mode == 1 && r < 70)
			return r[0] ? OP_PEEK_REAR : OP_PEEK_FRONT;
		return op_t'($urandom_range(OP_PEEK_REAR, OP_PUSH_FRONT));
	endfunction

	initial begin : stimulus
		int sent;
		int mode;
		int burst;

		// inputs and reset known from time zero, reset released on a falling edge
		src_idle_pct       = 0;
		snk_stall_pct      = 0;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.operation   = OP_PUSH_FRONT;
		req_ch.push_value  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: every read on an empty deque gives the empty error
		send_op(OP_POP_FRONT,  8'h00);
		send_op(OP_POP_REAR,   8'hFF);
		send_op(OP_PEEK_FRONT, 8'h00);
		send_op(OP_PEEK_REAR,  8'hFF);
		// extreme values through both ends; front push wraps the index below zero
		send_op(OP_PUSH_FRONT, 8'hFF);
		send_op(OP_PUSH_REAR,  8'h00);
		send_op(OP_PEEK_FRONT, 8'h5A);
		send_op(OP_PEEK_REAR,  8'hA5);
		send_op(OP_POP_FRONT,  8'h00);
		send_op(OP_POP_REAR,   8'h00);
		// fill to the brim from both ends, then overflow at each end
		for (int i = 0; i < DEQ_DEPTH; i++)
			send_op(i[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, 8'(i * 17 + 3));
		send_op(OP_PUSH_FRONT, 8'hC3);
		send_op(OP_PUSH_REAR,  8'h3C);

		// Random: four idling phases, the first with none at all
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 45; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 45; end
				default: begin src_idle_pct = 28; snk_stall_pct = 28; end
			endcase
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				mode  = $urandom_range(2);
				burst = $urandom_range(40, 8);
				for (int k = 0; k < burst && sent < RANDOM_PER_PHASE; k++) begin
					send_op(pick_op(mode), 8'($urandom_range(255)));
					sent++;
				end
			end
		end

		@(negedge clk);
		req_ch.valid <= 1'b0;

		// let the checker collect every outstanding response, then settle
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("double_ended_queue_top: match");
		end else begin
			$display("double_ended_queue_top: mismatch");
		end
		$finish;
	end

endmodule
